[rtl/triangle_fragment_depth_shader_core_macros.svh]
// Assertion macros for the triangle fragment depth shader core.
// Used by the RTL files that carry concurrent checks; needs a clk and a rst in scope.
`ifndef TRIANGLE_FRAGMENT_DEPTH_SHADER_CORE_MACROS_SVH
`define TRIANGLE_FRAGMENT_DEPTH_SHADER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TFDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TFDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tfds_pkg.sv]
// Shared types and constants of the triangle fragment depth shader core.
// No dependencies; imported by every module of the block.
package tfds_pkg;

  localparam int          MUL_W     = 33;
  localparam int          PROD_W    = 2 * MUL_W;
  localparam int          FRAC_T    = 30;
  localparam int          WP_BITS   = 24;
  localparam logic [31:0] FAR_DEPTH = 32'h7FFF_FFFF;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;

  // Control of the depth store port.
  typedef struct packed {
    logic rd;
    logic wr;
  } zb_ctl_t;

endpackage

[rtl/tfds_mul.sv]
// Shared signed multiplier of the shader core with a registered product.
// Depends on tfds_pkg for the operand and product widths.
module tfds_mul import tfds_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/tfds_zbuf.sv]
// Depth store of the shader core: one single-port memory with a clearing pass.
// Depends on tfds_pkg for the control struct and the far depth value.
module tfds_zbuf import tfds_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  zb_ctl_t       ctl,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata,
  output logic          busy
);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // After reset every entry is set to the far depth, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= FAR_DEPTH;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/triangle_fragment_depth_shader_core.sv]
// Top level of the triangle fragment depth shader core.
// Depends on tfds_pkg, tfds_mul, tfds_zbuf and the assertion macro header.
//
// The input channel (in_valid / in_ready) carries two kinds of transaction.
// A load transaction (func = 0) stores one triangle vertex: position in 12.4,
// z and w in 16.16 and an RGB colour; it gives no result.
// A shade transaction (func = 1) tests the centre of one pixel against the
// stored triangle and gives exactly one result transaction on the output
// channel (out_valid / out_ready): coverage, the perspective-correct depth,
// whether the depth store was written and, if so, the blended colour.
// The multiplications and divisions of the shading run through one
// registered 33x33 multiplier and one restoring divider under a sequencer,
// so a shade transaction is shortest when the centre is not covered and
// longest when it is covered and passes the depth test. The longest parts
// are the normalization of the w products, one bit per cycle, the three
// 30-step depth weight divisions and the three 9-step colour divisions.
// The block works on one pixel at a time: in_ready is low while a pixel is
// shaded. A finished result waits in the output registers for out_ready, so
// one more transaction can be taken meanwhile; the next finished result then
// holds the sequencer at its last step, and a stalled receiver holds the block.
// After reset the depth store is set to the farthest depth, one entry per
// cycle through the whole store, and in_ready stays low until that pass is
// over. Vertices hold no value after reset.
`include "triangle_fragment_depth_shader_core_macros.svh"

module triangle_fragment_depth_shader_core import tfds_pkg::*; #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [1:0]         vertex_slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [31:0] depth_z,
  input  logic [30:0]        clip_w,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [5:0]         pixel_x,
  input  logic [5:0]         pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_x,
  output logic [5:0]         out_y,
  output logic               covered,
  output logic               depth_written,
  output logic signed [31:0] fragment_depth,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE  = 4'd1;
  localparam logic [3:0] S_COV   = 4'd2;
  localparam logic [3:0] S_WP    = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_NUM   = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_DLOAD = 4'd7;
  localparam logic [3:0] S_DSTEP = 4'd8;
  localparam logic [3:0] S_ZMUL  = 4'd9;
  localparam logic [3:0] S_ZCHK  = 4'd10;
  localparam logic [3:0] S_ZCMP  = 4'd11;
  localparam logic [3:0] S_CMUL  = 4'd12;
  localparam logic [3:0] S_CLOAD = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // Vertex registers, indexed by vertex; colour also by channel.
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic signed [31:0] vz [3];
  logic [30:0]        vw [3];
  logic [7:0]         vc [3][3];

  logic [3:0]  state;
  logic [5:0]  cnt;
  logic [1:0]  k;
  logic [5:0]  px;
  logic [5:0]  py;

  // Working registers of one pixel.
  logic signed [35:0] n [3];
  logic signed [35:0] ntmp;
  logic [33:0]        an [3];
  logic [35:0]        dabs;
  logic [61:0]        wp [3];
  logic [2:0]         sticky;
  logic [61:0]        num [3];
  logic [61:0]        den;
  logic [30:0]        t [3];
  logic signed [65:0] zsum;
  logic signed [31:0] z;
  logic [45:0]        acc;
  logic [7:0]         col [3];
  logic               cov;
  logic               wrote;

  // Shared divider.
  logic [63:0] rem;
  logic [63:0] dv;
  logic [30:0] q;
  logic [4:0]  div_last;
  logic        div_col;
  logic        div_eq;
  logic [63:0] rem2;
  logic        div_ge;
  logic [63:0] rem_step;
  logic [30:0] q_step;

  // Shared multiplier.
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // Depth store port.
  zb_ctl_t       zb_ctl;
  logic [AW-1:0] zb_addr;
  logic [31:0]   zb_rdata;
  logic          zb_busy;
  logic          on_screen;

  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic [5:0]         pc;
  logic [1:0]         eu;
  logic [1:0]         ev;
  logic [1:0]         mi;
  logic               in_fire;

  assign in_ready = (state == S_IDLE) && !zb_busy;
  assign in_fire  = in_valid && in_ready;

  // Pixel centre in 12.4: 16 * pixel + 8.
  assign cx = 17'($signed({1'b0, px, 4'b1000}));
  assign cy = 17'($signed({1'b0, py, 4'b1000}));

  // Index of the operation whose product the multiplier gives now: the one issued in the previous cycle.
  assign pc = cnt - 6'd1;
  assign mi = cnt[2:1];

  always_comb begin
    unique case (cnt[2:1])
      2'd0:    begin eu = 2'd1; ev = 2'd2; end
      2'd1:    begin eu = 2'd2; ev = 2'd0; end
      2'd2:    begin eu = 2'd0; ev = 2'd1; end
      default: begin eu = 2'd0; ev = 2'd0; end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_EDGE: begin
        if (!cnt[0]) begin
          mul_a = MUL_W'(17'(vx[ev]) - 17'(vx[eu]));
          mul_b = MUL_W'(cy - 17'(vy[eu]));
        end else begin
          mul_a = MUL_W'(17'(vy[ev]) - 17'(vy[eu]));
          mul_b = MUL_W'(cx - 17'(vx[eu]));
        end
      end
      S_WP: begin
        unique case (cnt[1:0])
          2'd0:    begin mul_a = {2'b00, vw[1]}; mul_b = {2'b00, vw[2]}; end
          2'd1:    begin mul_a = {2'b00, vw[2]}; mul_b = {2'b00, vw[0]}; end
          2'd2:    begin mul_a = {2'b00, vw[0]}; mul_b = {2'b00, vw[1]}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_NUM: begin
        if (mi != 2'd3) begin
          mul_a = cnt[0] ? {16'd0, an[mi][33:17]} : {16'd0, an[mi][16:0]};
          mul_b = {8'd0, wp[mi][24:0]};
        end
      end
      S_ZMUL: begin
        if (cnt[1:0] != 2'd3) begin
          mul_a = {2'b00, t[cnt[1:0]]};
          mul_b = MUL_W'(vz[cnt[1:0]]);
        end
      end
      S_CMUL: begin
        if (mi != 2'd3) begin
          mul_a = cnt[0] ? {16'd0, an[mi][33:17]} : {16'd0, an[mi][16:0]};
          mul_b = {25'd0, vc[mi][k]};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tfds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // One restoring divider step: shift the remainder, compare, subtract.
  assign rem2     = {rem[62:0], 1'b0};
  assign div_ge   = rem2 >= dv;
  assign rem_step = div_ge ? rem2 - dv : rem2;
  assign q_step   = {q[29:0], div_ge};

  assign on_screen = (32'(px) < SCREEN_WIDTH) && (32'(py) < SCREEN_HEIGHT);
  assign zb_addr   = AW'(AW'(py) * AW'(SCREEN_WIDTH) + AW'(px));

  always_comb begin
    zb_ctl.rd = (state == S_ZCHK) && on_screen;
    zb_ctl.wr = (state == S_ZCMP) && (z < $signed(zb_rdata));
  end

  tfds_zbuf #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_zbuf (
    .clk   (clk),
    .rst   (rst),
    .ctl   (zb_ctl),
    .addr  (zb_addr),
    .wdata (z),
    .rdata (zb_rdata),
    .busy  (zb_busy)
  );

  // Vertex loads; a zero w is stored as one.
  always_ff @(posedge clk) begin
    if (in_fire && func == FUNC_LOAD && vertex_slot != 2'd3) begin
      vx[vertex_slot]    <= coord_x;
      vy[vertex_slot]    <= coord_y;
      vz[vertex_slot]    <= depth_z;
      vw[vertex_slot]    <= (clip_w == '0) ? 31'd1 : clip_w;
      vc[vertex_slot][0] <= red;
      vc[vertex_slot][1] <= green;
      vc[vertex_slot][2] <= blue;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && func == FUNC_SHADE) begin
            px    <= pixel_x;
            py    <= pixel_y;
            cnt   <= '0;
            wrote <= 1'b0;
            z     <= '0;
            col[0] <= '0;
            col[1] <= '0;
            col[2] <= '0;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (cnt != '0) begin
            if (!pc[0]) begin
              ntmp <= prod[35:0];
            end else begin
              n[pc[2:1]] <= ntmp - prod[35:0];
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd6) begin
            state <= S_COV;
          end
        end
        S_COV: begin
          cov     <= ((n[0] > 0) && (n[1] > 0) && (n[2] > 0)) ||
                     ((n[0] <= 0) && (n[1] <= 0) && (n[2] <= 0));
          for (int i = 0; i < 3; i++) begin
            an[i] <= n[i][35] ? 34'(-n[i]) : 34'(n[i]);
          end
          dabs <= 36'(n[0][35] ? -n[0] : n[0]) + 36'(n[1][35] ? -n[1] : n[1]) +
                  36'(n[2][35] ? -n[2] : n[2]);
          cnt  <= '0;
          // A zero-area triangle or an uncovered centre ends here.
          if ((((n[0] > 0) && (n[1] > 0) && (n[2] > 0)) ||
               ((n[0] <= 0) && (n[1] <= 0) && (n[2] <= 0))) &&
              (38'(n[0]) + 38'(n[1]) + 38'(n[2]) != '0)) begin
            state <= S_WP;
          end else begin
            state <= S_DONE;
          end
        end
        S_WP: begin
          if (cnt != '0) begin
            wp[pc[1:0]] <= prod[61:0];
          end
          sticky <= '0;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Shift all three products right until the largest fits in 24 bits,
          // keeping a sticky bit per product for the upward rounding.
          if ((|wp[0][61:WP_BITS]) || (|wp[1][61:WP_BITS]) || (|wp[2][61:WP_BITS])) begin
            for (int i = 0; i < 3; i++) begin
              wp[i]     <= wp[i] >> 1;
              sticky[i] <= sticky[i] | wp[i][0];
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              wp[i] <= wp[i] + 62'(sticky[i]);
            end
            cnt   <= '0;
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (cnt != '0) begin
            if (!pc[0]) begin
              num[pc[2:1]] <= 62'(prod[41:0]);
            end else begin
              num[pc[2:1]] <= num[pc[2:1]] + (62'(prod[41:0]) << 17);
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd6) begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den   <= num[0] + num[1] + num[2];
          k     <= '0;
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          rem      <= 64'(num[k]);
          dv       <= 64'(den);
          q        <= '0;
          cnt      <= '0;
          div_eq   <= num[k] >= den;
          div_col  <= 1'b0;
          div_last <= 5'(FRAC_T - 1);
          state    <= S_DSTEP;
        end
        S_DSTEP: begin
          rem <= rem_step;
          q   <= q_step;
          cnt <= cnt + 6'd1;
          if (cnt[4:0] == div_last) begin
            if (!div_col) begin
              t[k] <= div_eq ? 31'(1 << FRAC_T) : q_step;
              if (k == 2'd2) begin
                cnt   <= '0;
                zsum  <= '0;
                state <= S_ZMUL;
              end else begin
                k     <= k + 2'd1;
                state <= S_DLOAD;
              end
            end else begin
              col[k] <= (q_step > 31'd255) ? 8'd255 : q_step[7:0];
              if (k == 2'd2) begin
                state <= S_DONE;
              end else begin
                k     <= k + 2'd1;
                cnt   <= '0;
                acc   <= '0;
                state <= S_CMUL;
              end
            end
          end
        end
        S_ZMUL: begin
          if (cnt != '0) begin
            zsum <= zsum + prod;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            // Arithmetic shift gives the floor for both signs.
            z     <= 32'((zsum + prod) >>> FRAC_T);
            state <= S_ZCHK;
          end
        end
        S_ZCHK: begin
          state <= on_screen ? S_ZCMP : S_DONE;
        end
        S_ZCMP: begin
          if (z < $signed(zb_rdata)) begin
            wrote <= 1'b1;
            k     <= '0;
            cnt   <= '0;
            acc   <= '0;
            state <= S_CMUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_CMUL: begin
          if (cnt != '0) begin
            if (!pc[0]) begin
              acc <= acc + 46'(prod[24:0]);
            end else begin
              acc <= acc + (46'(prod[24:0]) << 17);
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd6) begin
            state <= S_CLOAD;
          end
        end
        S_CLOAD: begin
          // Round half up: (2 * acc + D) / (2 * D), run as a 9-bit division.
          rem      <= 64'({acc, 1'b0}) + 64'(dabs);
          dv       <= 64'({dabs, 1'b0}) << 9;
          q        <= '0;
          cnt      <= '0;
          div_eq   <= 1'b0;
          div_col  <= 1'b1;
          div_last <= 5'd8;
          state    <= S_DSTEP;
        end
        S_DONE: begin
          // The result waits here while the previous one is still held.
          if (!out_valid || out_ready) begin
            out_x          <= px;
            out_y          <= py;
            covered        <= cov;
            depth_written  <= wrote;
            fragment_depth <= z;
            red_out        <= col[0];
            green_out      <= col[1];
            blue_out       <= col[2];
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TFDS_ASSERT_NXT(a_result_held, out_valid && !out_ready,
                   out_valid && $stable(fragment_depth) && $stable(out_x),
                   "result changed while waiting for out_ready")
  `TFDS_ASSERT_IMP(a_clear_blocks_input, zb_busy, !in_ready,
                   "input taken during the depth store clearing pass")
  `TFDS_ASSERT_NXT(a_shade_starts, in_valid && in_ready && func == FUNC_SHADE,
                   state == S_EDGE, "shade transaction did not start the sequencer")
  `TFDS_ASSERT_IMP(a_write_after_read, zb_ctl.wr, $past(zb_ctl.rd) && state == S_ZCMP,
                   "depth store written without a preceding read")
  `TFDS_ASSERT_IMP(a_written_covered, out_valid && depth_written, covered,
                   "depth written for an uncovered pixel")

endmodule
